// ===== rtl/core/fafu_pkg.sv =====
// ----------------------------------------------------------------------------
// fafu_pkg
// Shared types, widths and codes of the five-channel fade and flash unit.
// ----------------------------------------------------------------------------
package fafu_pkg;

   localparam int LANES   = 5;
   localparam int LANE_W  = $clog2(LANES);
   localparam int LEVEL_W = 16;
   localparam int COUNT_W = 12;
   localparam int MS_W    = 16;
   localparam int OP_W    = 3;
   // dividend holds a level difference times a tick count
   localparam int PROD_W  = LEVEL_W + COUNT_W;

   localparam int TICK_MS_DEFAULT      = 20;
   localparam int BLINK_PERIOD_DEFAULT = 25;

   typedef logic [LEVEL_W-1:0]      level_type;
   typedef level_type [LANES-1:0]   level_vec_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_DIM     = 3'd1,
      OP_FLASH   = 3'd2,
      OP_REQUEST = 3'd3,
      OP_POLL    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      DIV_TICKS,
      DIV_FADE,
      DIV_PHASE
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_FADE,
      S_FADE_WAIT,
      S_BLINK,
      S_BLINK_WAIT,
      S_CONV,
      S_CONV_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              fade_step;
      logic              div_start;
      div_sel_type       div_sel;
      logic              fade_write;
      logic              blink_write;
      logic              conv_write;
      logic              load_out;
      logic [LANE_W-1:0] lane;
   } cmd_type;

   typedef struct packed {
      logic fade_active;
      logic fade_total_zero;
      logic blink_active;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/five_channel_fade_and_flash_unit.sv =====
// ----------------------------------------------------------------------------
// five_channel_fade_and_flash_unit
// Five 16-bit colour levels with linear fade and periodic flash.
// ----------------------------------------------------------------------------
// One transaction is worked at a time and every transaction returns one
// result. Each fading lane goes through one shared restoring divider that
// yields one quotient bit per cycle (28 quotient bits), one lane after the
// other. The divisions by the tick length and by the flash period are
// reciprocal multiplications whose quotient is registered for the write
// state. A tick steps an active fade through the lanes and then an active
// flash; a dim or flash command converts its duration to ticks; the update
// request, poll and unused codes go straight to the result. A new
// transaction is accepted as soon as the previous result sits in the output
// register; a stalled result holds the block until the output register
// frees.
module five_channel_fade_and_flash_unit #(
   parameter int TICK_MS            = fafu_pkg::TICK_MS_DEFAULT,
   parameter int BLINK_PERIOD_TICKS = fafu_pkg::BLINK_PERIOD_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fafu_pkg::OP_W-1:0]     req_operation,
   input  logic [fafu_pkg::LEVEL_W-1:0]  req_red_in,
   input  logic [fafu_pkg::LEVEL_W-1:0]  req_green_in,
   input  logic [fafu_pkg::LEVEL_W-1:0]  req_blue_in,
   input  logic [fafu_pkg::LEVEL_W-1:0]  req_warm_in,
   input  logic [fafu_pkg::LEVEL_W-1:0]  req_cool_in,
   input  logic [fafu_pkg::MS_W-1:0]     req_duration_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fafu_pkg::LEVEL_W-1:0]  rsp_red_out,
   output logic [fafu_pkg::LEVEL_W-1:0]  rsp_green_out,
   output logic [fafu_pkg::LEVEL_W-1:0]  rsp_blue_out,
   output logic [fafu_pkg::LEVEL_W-1:0]  rsp_warm_out,
   output logic [fafu_pkg::LEVEL_W-1:0]  rsp_cool_out,
   output logic                          rsp_changed_flag
);
   import fafu_pkg::*;

   cmd_type       cmd;
   status_type    status;
   level_vec_type req_level;
   level_vec_type rsp_level;

   assign req_level = {req_cool_in, req_warm_in, req_blue_in, req_green_in, req_red_in};

   fafu_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   fafu_datapath #(
      .TICK_MS            (TICK_MS),
      .BLINK_PERIOD_TICKS (BLINK_PERIOD_TICKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_level        (req_level),
      .req_duration_ms  (req_duration_ms),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_level        (rsp_level),
      .rsp_changed_flag (rsp_changed_flag)
   );

   assign rsp_red_out   = rsp_level[0];
   assign rsp_green_out = rsp_level[1];
   assign rsp_blue_out  = rsp_level[2];
   assign rsp_warm_out  = rsp_level[3];
   assign rsp_cool_out  = rsp_level[4];

endmodule

// ===== rtl/core/fafu_divider.sv =====
// ----------------------------------------------------------------------------
// fafu_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fafu_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fafu_pkg::PROD_W-1:0]   dividend,
   input  logic [fafu_pkg::COUNT_W-1:0]  divisor,
   output logic                          done,
   output logic [fafu_pkg::PROD_W-1:0]   quotient
);
   import fafu_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   logic [COUNT_W:0]   shifted;
   logic [COUNT_W:0]   trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quo_ff[PROD_W-1]};
      trial      = shifted - {1'b0, divisor_ff};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         if (!trial[COUNT_W]) begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/core/fafu_datapath.sv =====
// ----------------------------------------------------------------------------
// fafu_datapath
// Level, fade and flash state, the shared divider and the result register.
// ----------------------------------------------------------------------------
module fafu_datapath #(
   parameter int TICK_MS            = fafu_pkg::TICK_MS_DEFAULT,
   parameter int BLINK_PERIOD_TICKS = fafu_pkg::BLINK_PERIOD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fafu_pkg::cmd_type            cmd,
   output fafu_pkg::status_type         status,
   input  logic [fafu_pkg::OP_W-1:0]    req_operation,
   input  fafu_pkg::level_vec_type      req_level,
   input  logic [fafu_pkg::MS_W-1:0]    req_duration_ms,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output fafu_pkg::level_vec_type      rsp_level,
   output logic                         rsp_changed_flag
);
   import fafu_pkg::*;

   localparam int     LIT_MAX      = (BLINK_PERIOD_TICKS - 1) / 2;
   // reciprocals exact for every dividend of the given width
   localparam int     TICK_SHIFT   = MS_W + $clog2(TICK_MS);
   localparam longint TICK_RECIP   = ((longint'(1) << TICK_SHIFT) + longint'(TICK_MS - 1))
                                     / longint'(TICK_MS);
   localparam int     PHASE_SHIFT  = COUNT_W + $clog2(BLINK_PERIOD_TICKS);
   localparam longint PHASE_RECIP  = ((longint'(1) << PHASE_SHIFT)
                                     + longint'(BLINK_PERIOD_TICKS - 1))
                                     / longint'(BLINK_PERIOD_TICKS);
   localparam int     TICK_PROD_W  = 2 * MS_W + 2;
   localparam int     PHASE_PROD_W = 2 * COUNT_W + 2;

   level_vec_type current_ff, current_in;
   level_vec_type start_ff, start_in;
   level_vec_type goal_ff, goal_in;
   level_vec_type blink_ff, blink_in;
   count_type     fade_left_ff, fade_left_in;
   count_type     fade_total_ff, fade_total_in;
   count_type     blink_left_ff, blink_left_in;
   logic          pending_ff, pending_in;
   op_type        op_ff, op_in;
   logic [MS_W-1:0] ms_ff, ms_in;
   logic [MS_W-1:0] quot_ff, quot_in;
   logic          fade_neg_ff, fade_neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   level_vec_type rsp_level_ff, rsp_level_in;
   logic          rsp_flag_ff, rsp_flag_in;

   logic                 div_start;
   logic [PROD_W-1:0]    div_dividend;
   logic [COUNT_W-1:0]   div_divisor;
   logic                 div_done;
   logic [PROD_W-1:0]    div_quotient;

   logic [TICK_PROD_W-1:0]  tick_prod;
   logic [PHASE_PROD_W-1:0] phase_prod;
   logic [MS_W-1:0]         tick_quot;
   count_type               phase_quot;
   count_type               phase_rem;

   level_type lane_start;
   level_type lane_goal;
   level_type lane_mag;
   logic      lane_neg;
   count_type fade_done;
   count_type ticks;
   level_type step;
   logic      lit;

   fafu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   always_comb begin
      lane_start = start_ff[cmd.lane];
      lane_goal  = goal_ff[cmd.lane];
      lane_neg   = lane_goal < lane_start;
      lane_mag   = lane_neg ? (lane_start - lane_goal) : (lane_goal - lane_start);
      fade_done  = fade_total_ff - fade_left_ff;
      div_start  = cmd.div_start && (cmd.div_sel == DIV_FADE);
      // magnitude times progress; sign applied after the divide
      div_dividend = PROD_W'(lane_mag) * PROD_W'(fade_done);
      div_divisor  = fade_total_ff;
      tick_prod  = TICK_PROD_W'(ms_ff) * TICK_PROD_W'(TICK_RECIP);
      tick_quot  = MS_W'(tick_prod >> TICK_SHIFT);
      phase_prod = PHASE_PROD_W'(blink_left_ff) * PHASE_PROD_W'(PHASE_RECIP);
      phase_quot = COUNT_W'(phase_prod >> PHASE_SHIFT);
      // saturate the tick count to the counter width
      ticks = (quot_ff[MS_W-1:COUNT_W] != '0) ? '1 : quot_ff[COUNT_W-1:0];
      step  = div_quotient[LEVEL_W-1:0];
      phase_rem = blink_left_ff - quot_ff[COUNT_W-1:0] * COUNT_W'(BLINK_PERIOD_TICKS);
      lit   = phase_rem <= COUNT_W'(LIT_MAX);
   end

   always_comb begin
      current_in    = current_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      blink_in      = blink_ff;
      fade_left_in  = fade_left_ff;
      fade_total_in = fade_total_ff;
      blink_left_in = blink_left_ff;
      pending_in    = pending_ff;
      op_in         = op_ff;
      ms_in         = ms_ff;
      quot_in       = quot_ff;
      fade_neg_in   = fade_neg_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.accept) begin
         op_in = op_type'(req_operation);
         ms_in = req_duration_ms;
         case (op_type'(req_operation))
            OP_DIM: begin
               start_in = current_ff;
               goal_in  = req_level;
            end
            OP_FLASH:   blink_in   = req_level;
            OP_REQUEST: pending_in = 1'b1;
            default: ;
         endcase
      end

      if (cmd.fade_step) begin
         fade_left_in = fade_left_ff - 1'b1;
         pending_in   = 1'b1;
         if (fade_total_ff == '0) begin
            current_in = goal_ff;
         end
      end

      if (cmd.div_start && cmd.div_sel == DIV_FADE) begin
         fade_neg_in = lane_neg;
      end

      // hold the constant-divisor quotient for the write cycle
      if (cmd.div_start && cmd.div_sel == DIV_TICKS) begin
         quot_in = tick_quot;
      end

      if (cmd.div_start && cmd.div_sel == DIV_PHASE) begin
         quot_in = MS_W'(phase_quot);
      end

      if (cmd.fade_write) begin
         current_in[cmd.lane] = fade_neg_ff ? (lane_start - step) : (lane_start + step);
      end

      if (cmd.blink_write) begin
         for (int i = 0; i < LANES; i++) begin
            current_in[i] = lit ? blink_ff[i] : '0;
         end
         blink_left_in = blink_left_ff - 1'b1;
         pending_in    = 1'b1;
      end

      if (cmd.conv_write) begin
         if (op_ff == OP_DIM) begin
            fade_left_in  = ticks;
            fade_total_in = ticks;
         end else begin
            blink_left_in = ticks;
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = current_ff;
         rsp_flag_in  = pending_ff;
         if (op_ff == OP_POLL) begin
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff    <= '0;
         start_ff      <= '0;
         goal_ff       <= '0;
         blink_ff      <= '0;
         fade_left_ff  <= '0;
         fade_total_ff <= '0;
         blink_left_ff <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         current_ff    <= current_in;
         start_ff      <= start_in;
         goal_ff       <= goal_in;
         blink_ff      <= blink_in;
         fade_left_ff  <= fade_left_in;
         fade_total_ff <= fade_total_in;
         blink_left_ff <= blink_left_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      ms_ff        <= ms_in;
      quot_ff      <= quot_in;
      fade_neg_ff  <= fade_neg_in;
      rsp_level_ff <= rsp_level_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign status.fade_active     = fade_left_ff != '0;
   assign status.fade_total_zero = fade_total_ff == '0;
   assign status.blink_active    = blink_left_ff != '0;
   assign status.div_done        = div_done;
   assign status.out_free        = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_changed_flag = rsp_flag_ff;

endmodule

// ===== rtl/core/fafu_controller.sv =====
// ----------------------------------------------------------------------------
// fafu_controller
// Sequencer: accepts a transaction, walks the lanes through the divider,
// steps the flash or converts durations, then loads the output register.
// ----------------------------------------------------------------------------
module fafu_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [fafu_pkg::OP_W-1:0]    req_operation,
   output logic                         req_ready,
   input  fafu_pkg::status_type         status,
   output fafu_pkg::cmd_type            cmd
);
   import fafu_pkg::*;

   state_type         state_ff, state_in;
   logic [LANE_W-1:0] lane_ff, lane_in;

   always_comb begin
      state_in  = state_ff;
      lane_in   = lane_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.lane  = lane_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (op_type'(req_operation))
                  OP_TICK:  state_in = S_TICK;
                  OP_DIM:   state_in = S_CONV;
                  OP_FLASH: state_in = S_CONV;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_TICK: begin
            if (status.fade_active) begin
               cmd.fade_step = 1'b1;
               lane_in       = '0;
               state_in      = status.fade_total_zero ? S_BLINK : S_FADE;
            end else begin
               state_in = S_BLINK;
            end
         end
         S_FADE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FADE;
            state_in      = S_FADE_WAIT;
         end
         S_FADE_WAIT: begin
            if (status.div_done) begin
               cmd.fade_write = 1'b1;
               if (lane_ff == LANE_W'(LANES - 1)) begin
                  state_in = S_BLINK;
               end else begin
                  lane_in  = lane_ff + 1'b1;
                  state_in = S_FADE;
               end
            end
         end
         S_BLINK: begin
            if (status.blink_active) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PHASE;
               state_in      = S_BLINK_WAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BLINK_WAIT: begin
            cmd.blink_write = 1'b1;
            state_in        = S_DONE;
         end
         S_CONV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TICKS;
            state_in      = S_CONV_WAIT;
         end
         S_CONV_WAIT: begin
            cmd.conv_write = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lane_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
      end
   end

endmodule

// ===== dv/five_channel_fade_and_flash_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_channel_fade_and_flash_unit_tb
// Self-checking bench for the five-channel fade and flash unit: a short
// directed sequence, then weighted random commands with random stalls on
// both channels. A scoreboard mirrors the fade and flash state and checks
// every result in order.
// ----------------------------------------------------------------------------

typedef struct packed {
   fafu_pkg::level_vec_type levels;
   logic                    changed;
} lamp_reading_type;

class lamp_scoreboard;
   localparam int unsigned TICK_LEN  = 20;
   localparam int unsigned PERIOD    = 25;
   localparam int unsigned TICKS_MAX = 4095;

   fafu_pkg::level_vec_type now_lv;
   fafu_pkg::level_vec_type from_lv;
   fafu_pkg::level_vec_type to_lv;
   fafu_pkg::level_vec_type flash_lv;
   int unsigned             fade_remaining;
   int unsigned             fade_span;
   int unsigned             flash_remaining;
   bit                      update_pending;
   lamp_reading_type        expected_readings[$];
   int unsigned             mismatch_count;

   function new();
      now_lv          = '0;
      from_lv         = '0;
      to_lv           = '0;
      flash_lv        = '0;
      fade_remaining  = 0;
      fade_span       = 0;
      flash_remaining = 0;
      update_pending  = 1'b0;
      mismatch_count  = 0;
   endfunction

   function int unsigned ticks_for(logic [fafu_pkg::MS_W-1:0] ms);
      int unsigned t;
      t = ms / TICK_LEN;
      return (t > TICKS_MAX) ? TICKS_MAX : t;
   endfunction

   function void advance_tick();
      longint diff;
      longint done;
      longint base;
      longint goal;
      longint v;
      bit     lit;
      if (fade_remaining != 0) begin
         fade_remaining--;
         for (int i = 0; i < fafu_pkg::LANES; i++) begin
            if (fade_span == 0) begin
               now_lv[i] = to_lv[i];
            end else begin
               base = from_lv[i];
               goal = to_lv[i];
               diff = goal - base;
               done = longint'(fade_span) - longint'(fade_remaining);
               // signed division truncates toward zero
               v = diff * done / longint'(fade_span) + base;
               now_lv[i] = v[fafu_pkg::LEVEL_W-1:0];
            end
         end
         update_pending = 1'b1;
      end
      if (flash_remaining != 0) begin
         lit = (flash_remaining % PERIOD) <= ((PERIOD - 1) / 2);
         for (int i = 0; i < fafu_pkg::LANES; i++)
            now_lv[i] = lit ? flash_lv[i] : '0;
         flash_remaining--;
         update_pending = 1'b1;
      end
   endfunction

   function void note_request(logic [fafu_pkg::OP_W-1:0] op,
                              fafu_pkg::level_vec_type lv,
                              logic [fafu_pkg::MS_W-1:0] ms);
      lamp_reading_type exp_r;
      case (op)
         fafu_pkg::OP_TICK: begin
            advance_tick();
         end
         fafu_pkg::OP_DIM: begin
            from_lv        = now_lv;
            to_lv          = lv;
            fade_remaining = ticks_for(ms);
            fade_span      = fade_remaining;
         end
         fafu_pkg::OP_FLASH: begin
            flash_lv        = lv;
            flash_remaining = ticks_for(ms);
         end
         fafu_pkg::OP_REQUEST: begin
            update_pending = 1'b1;
         end
         default: begin
         end
      endcase
      exp_r.levels  = now_lv;
      exp_r.changed = update_pending;
      // poll reports the flag before clearing it
      if (op == fafu_pkg::OP_POLL)
         update_pending = 1'b0;
      expected_readings.push_back(exp_r);
   endfunction

   task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatch_count++;
   endtask

   task check_reading(lamp_reading_type got);
      lamp_reading_type exp_r;
      string            lane_names[fafu_pkg::LANES];
      lane_names = '{"red", "green", "blue", "warm", "cool"};
      if (expected_readings.size() == 0) begin
         report_mismatch("result with no transaction outstanding");
         return;
      end
      exp_r = expected_readings.pop_front();
      for (int i = 0; i < fafu_pkg::LANES; i++) begin
         if (got.levels[i] !== exp_r.levels[i])
            report_mismatch($sformatf("%s got %h exp %h", lane_names[i],
                                      got.levels[i], exp_r.levels[i]));
      end
      if (got.changed !== exp_r.changed)
         report_mismatch($sformatf("changed_flag got %b exp %b",
                                   got.changed, exp_r.changed));
   endtask

   function int unsigned outstanding();
      return expected_readings.size();
   endfunction
endclass

module five_channel_fade_and_flash_unit_tb;

   localparam logic [fafu_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [fafu_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
   localparam logic [fafu_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_ITEMS   = 100;
   localparam int DRAIN_AT     = 300;
   localparam int SETTLE_CYCLES = 400;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [fafu_pkg::OP_W-1:0]     req_operation = '0;
   logic [fafu_pkg::LEVEL_W-1:0]  req_red_in = '0;
   logic [fafu_pkg::LEVEL_W-1:0]  req_green_in = '0;
   logic [fafu_pkg::LEVEL_W-1:0]  req_blue_in = '0;
   logic [fafu_pkg::LEVEL_W-1:0]  req_warm_in = '0;
   logic [fafu_pkg::LEVEL_W-1:0]  req_cool_in = '0;
   logic [fafu_pkg::MS_W-1:0]     req_duration_ms = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [fafu_pkg::LEVEL_W-1:0]  rsp_red_out;
   logic [fafu_pkg::LEVEL_W-1:0]  rsp_green_out;
   logic [fafu_pkg::LEVEL_W-1:0]  rsp_blue_out;
   logic [fafu_pkg::LEVEL_W-1:0]  rsp_warm_out;
   logic [fafu_pkg::LEVEL_W-1:0]  rsp_cool_out;
   logic                          rsp_changed_flag;

   lamp_scoreboard lamps = new();
   bit             idling_on = 1'b1;
   int unsigned    rsp_stall_left = 0;

   five_channel_fade_and_flash_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_warm_in      (req_warm_in),
      .req_cool_in      (req_cool_in),
      .req_duration_ms  (req_duration_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_warm_out     (rsp_warm_out),
      .rsp_cool_out     (rsp_cool_out),
      .rsp_changed_flag (rsp_changed_flag)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // result side: random stall bursts, one update per edge
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left <= $urandom_range(0, 7);
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      lamp_reading_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.levels  = {rsp_cool_out, rsp_warm_out, rsp_blue_out,
                        rsp_green_out, rsp_red_out};
         got.changed = rsp_changed_flag;
         lamps.check_reading(got);
      end
   end

   task automatic send_request(input logic [fafu_pkg::OP_W-1:0] op,
                               input fafu_pkg::level_vec_type lv,
                               input logic [fafu_pkg::MS_W-1:0] ms);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_red_in      <= lv[0];
      req_green_in    <= lv[1];
      req_blue_in     <= lv[2];
      req_warm_in     <= lv[3];
      req_cool_in     <= lv[4];
      req_duration_ms <= ms;
      do @(posedge clock); while (!req_ready);
      lamps.note_request(op, lv, ms);
   endtask

   function automatic fafu_pkg::level_type pick_level();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 4) return '1;
      return fafu_pkg::level_type'($urandom);
   endfunction

   function automatic fafu_pkg::level_vec_type pick_levels();
      fafu_pkg::level_vec_type lv;
      for (int i = 0; i < fafu_pkg::LANES; i++)
         lv[i] = pick_level();
      return lv;
   endfunction

   function automatic logic [fafu_pkg::MS_W-1:0] pick_duration();
      int unsigned r;
      r = $urandom_range(0, 99);
      // keep most runs short so fades finish and flashes alternate
      if (r < 35) return fafu_pkg::MS_W'($urandom_range(0, 500));
      if (r < 75) return fafu_pkg::MS_W'($urandom_range(500, 2000));
      if (r < 85) return fafu_pkg::MS_W'($urandom);
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd19;
         2: return 16'd20;
         3: return 16'd39;
         4: return 16'd40;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [fafu_pkg::OP_W-1:0] pick_operation();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return fafu_pkg::OP_TICK;
      if (r < 68) return fafu_pkg::OP_DIM;
      if (r < 80) return fafu_pkg::OP_FLASH;
      if (r < 87) return fafu_pkg::OP_REQUEST;
      if (r < 95) return fafu_pkg::OP_POLL;
      return fafu_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   initial begin
      fafu_pkg::level_vec_type mixed;
      mixed = {16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: flag handling, sub-tick and single-tick fades, fade down,
      // overlapping fade and flash, spare codes, zero-length flash
      send_request(fafu_pkg::OP_TICK,    '0, 16'd0);
      send_request(fafu_pkg::OP_POLL,    '0, 16'd0);
      send_request(fafu_pkg::OP_REQUEST, '0, 16'd0);
      send_request(fafu_pkg::OP_POLL,    '0, 16'd0);
      send_request(fafu_pkg::OP_POLL,    '0, 16'd0);
      send_request(fafu_pkg::OP_DIM,     '1, 16'd19);
      send_request(fafu_pkg::OP_TICK,    '0, 16'd0);
      send_request(fafu_pkg::OP_DIM,     '1, 16'd20);
      send_request(fafu_pkg::OP_TICK,    '0, 16'd0);
      send_request(fafu_pkg::OP_POLL,    '0, 16'd0);
      send_request(fafu_pkg::OP_DIM,     '0, 16'd100);
      repeat (3) send_request(fafu_pkg::OP_TICK, '0, 16'd0);
      send_request(fafu_pkg::OP_FLASH,   mixed, 16'd60);
      repeat (2) send_request(fafu_pkg::OP_TICK, '0, 16'd0);
      send_request(fafu_pkg::OP_DIM,     ~mixed, 16'hFFFF);
      repeat (2) send_request(fafu_pkg::OP_TICK, '0, 16'd0);
      send_request(OP_SPARE_FIRST,       '1, 16'hFFFF);
      send_request(OP_SPARE_MID,         '0, 16'd0);
      send_request(OP_SPARE_LAST,        '1, 16'hFFFF);
      send_request(fafu_pkg::OP_FLASH,   '1, 16'd0);
      send_request(fafu_pkg::OP_TICK,    '0, 16'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            idling_on = 1'b0;
         if (n == DRAIN_AT) begin
            // hold the sender until every result is back
            req_valid <= 1'b0;
            while (lamps.outstanding() != 0) @(posedge clock);
            @(posedge clock);
         end
         send_request(pick_operation(), pick_levels(), pick_duration());
      end
      req_valid <= 1'b0;

      while (lamps.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lamps.outstanding() != 0)
         lamps.report_mismatch("results never returned");
      if (lamps.mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
